/* sv/knps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knps_pkg
// Shared types and constants of the k-nearest point selector.
// ----------------------------------------------------------------------------
package knps_pkg;

    localparam int K_MAX_DEF      = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int ID_BITS_DEF    = 16;

    localparam int RANK_W     = 4;
    localparam int NC_W       = 5;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_X        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_Y        = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_Z        = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEIGHBOR_COUNT = 2'd3;

    localparam logic [NC_W-1:0] NC_RESET = 5'd1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_COUNT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              in_open;
        logic              shift_out;
        logic              clear_held;
        logic              out_load;
        logic              out_found;
        logic              out_last;
        logic [RANK_W-1:0] out_rank;
    } t_dp_cmd;

    typedef struct packed {
        logic            end_pending;
        logic            end_insert;
        logic            out_free;
        logic [NC_W-1:0] nc;
    } t_dp_sts;

endpackage

/* sv/k_nearest_point_select_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_point_select_core
// Keeps the k points of a stream nearest to a query point, reports them in
// ascending squared distance at the end of each batch.
// ----------------------------------------------------------------------------
// usage
// - write query x, y, z and the neighbor count on the cfg port while idle
// - candidate beats enter on s_axis, tlast marks the last of a batch
// - a candidate passes through the distance pipeline and insert cell chain;
//   ordinary candidates are taken one per cycle while the input is open
// - on a tlast beat the input closes; once the batch end has passed the
//   pipeline, the first result beat appears on m_axis, then one beat per
//   cycle while m_axis is ready, nearest first, tlast on the last; tuser
//   low with zero payload means nothing was held or the neighbor count is zero
// - input reopens after the last beat loads; a point at distance zero is dropped
// - the output register lets the next batch start while the last beat waits
// - a stalled m_axis holds the current beat and pauses the report
// - reset clears the held list, query to the origin, neighbor count to 1
// ----------------------------------------------------------------------------
module k_nearest_point_select_core
    import knps_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    localparam int CNT_W     = $clog2(K_MAX + 1),
    localparam int DIST_W    = 2 * COORD_BITS + 2,
    localparam int IN_W      = ID_BITS + 3 * COORD_BITS,
    localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = RANK_W + ID_BITS + DIST_W,
    localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COORD_BITS-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TD_W-1:0]    s_axis_tdata,  // cand_id, cand_x, cand_y, cand_z
    input  logic                  s_axis_tlast,  // batch_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_TD_W-1:0]   m_axis_tdata,  // rank, point_id, sq_distance
    output logic [0:0]            m_axis_tuser,  // found
    output logic                  m_axis_tlast   // run_last
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [CNT_W-1:0] w_held;

    knps_datapath #(
        .K_MAX      (K_MAX),
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_held        (w_held)
    );

    knps_ctrl #(
        .K_MAX (K_MAX)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .i_held  (w_held),
        .o_cmd   (w_cmd)
    );

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_held <= CNT_W'(K_MAX))
        else $error("held count above list depth");

    a_closed_on_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.shift_out |-> !s_axis_tready)
        else $error("input open while the list is read out");

    a_closed_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.end_insert |-> !s_axis_tready)
        else $error("input open while a batch end is inserted");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("beat loaded over a waiting beat");

    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_held |-> (w_cmd.out_load && w_cmd.out_last))
        else $error("list cleared outside the last beat");

endmodule

/* sv/knps_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knps_datapath
// Distance pipeline, sorted compare-and-shift cell chain, config registers
// and the output beat register.
// ----------------------------------------------------------------------------
module knps_datapath
    import knps_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    localparam int CNT_W     = $clog2(K_MAX + 1),
    localparam int DIST_W    = 2 * COORD_BITS + 2,
    localparam int IN_W      = ID_BITS + 3 * COORD_BITS,
    localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = RANK_W + ID_BITS + DIST_W,
    localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COORD_BITS-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TD_W-1:0]    s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_TD_W-1:0]   m_axis_tdata,
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [CNT_W-1:0]      o_held
);

    localparam int CW    = COORD_BITS;
    localparam int X_LSB = ID_BITS;
    localparam int Y_LSB = ID_BITS + CW;
    localparam int Z_LSB = ID_BITS + 2 * CW;

    logic signed [CW-1:0] r_qx, r_qy, r_qz;
    logic [NC_W-1:0]      r_nc;

    logic                 r_v1, r_v2, r_v3;
    logic                 r_e1, r_e2, r_e3;
    logic [ID_BITS-1:0]   r_id1, r_id2, r_id3;
    logic signed [CW:0]   r_dx, r_dy, r_dz;
    logic [DIST_W-1:0]    r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]    r_sum;

    logic [DIST_W-1:0]    r_cd  [K_MAX];
    logic [ID_BITS-1:0]   r_cid [K_MAX];
    logic [CNT_W-1:0]     r_held;

    logic                 r_ovalid;
    logic                 r_ofound;
    logic                 r_olast;
    logic [RANK_W-1:0]    r_orank;
    logic [ID_BITS-1:0]   r_oid;
    logic [DIST_W-1:0]    r_odist;

    logic                 w_accept;
    logic                 w_insert;
    logic signed [CW-1:0] w_cx, w_cy, w_cz;
    logic [CW:0]          w_mx, w_my, w_mz;
    logic [K_MAX-1:0]     w_after;
    logic [K_MAX-1:0]     w_after_prev;

    assign w_cx = s_axis_tdata[X_LSB +: CW];
    assign w_cy = s_axis_tdata[Y_LSB +: CW];
    assign w_cz = s_axis_tdata[Z_LSB +: CW];

    assign o_sts.end_pending = (r_v1 & r_e1) | (r_v2 & r_e2) | (r_v3 & r_e3);
    assign o_sts.end_insert  = r_v3 & r_e3;
    assign o_sts.out_free    = ~r_ovalid | m_axis_tready;
    assign o_sts.nc          = r_nc;
    assign o_held            = r_held;

    assign s_axis_tready = i_cmd.in_open & ~o_sts.end_pending;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_insert      = r_v3 & (r_sum != '0);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_nc <= NC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_QUERY_X:        r_qx <= i_cfg_wdata;
                CFG_QUERY_Y:        r_qy <= i_cfg_wdata;
                CFG_QUERY_Z:        r_qz <= i_cfg_wdata;
                CFG_NEIGHBOR_COUNT: r_nc <= i_cfg_wdata[NC_W-1:0];
                default:            r_nc <= r_nc;
            endcase
        end
    end

    // pipeline valid and control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // magnitudes of the differences
    always_comb begin
        w_mx = r_dx[CW] ? (CW + 1)'(-r_dx) : (CW + 1)'(r_dx);
        w_my = r_dy[CW] ? (CW + 1)'(-r_dy) : (CW + 1)'(r_dy);
        w_mz = r_dz[CW] ? (CW + 1)'(-r_dz) : (CW + 1)'(r_dz);
    end

    // distance pipeline payload
    always_ff @(posedge i_clk) begin
        r_e1  <= s_axis_tlast;
        r_id1 <= s_axis_tdata[ID_BITS-1:0];
        r_dx  <= {w_cx[CW-1], w_cx} - {r_qx[CW-1], r_qx};
        r_dy  <= {w_cy[CW-1], w_cy} - {r_qy[CW-1], r_qy};
        r_dz  <= {w_cz[CW-1], w_cz} - {r_qz[CW-1], r_qz};
        r_e2  <= r_e1;
        r_id2 <= r_id1;
        r_sqx <= w_mx * w_mx;
        r_sqy <= w_my * w_my;
        r_sqz <= w_mz * w_mz;
        r_e3  <= r_e2;
        r_id3 <= r_id2;
        r_sum <= r_sqx + r_sqy + r_sqz;
    end

    // each cell: does the new point sit at or ahead of this slot
    always_comb begin
        for (int i = 0; i < K_MAX; i++) begin
            w_after[i] = (CNT_W'(i) >= r_held) | (r_sum <= r_cd[i]);
        end
        w_after_prev[0] = 1'b0;
        for (int i = 1; i < K_MAX; i++) begin
            w_after_prev[i] = w_after[i-1];
        end
    end

    // cell chain
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            for (int i = 0; i < K_MAX; i++) begin
                if (w_after[i]) begin
                    if (w_after_prev[i]) begin
                        r_cd[i]  <= r_cd[(i > 0) ? i - 1 : 0];
                        r_cid[i] <= r_cid[(i > 0) ? i - 1 : 0];
                    end else begin
                        r_cd[i]  <= r_sum;
                        r_cid[i] <= r_id3;
                    end
                end
            end
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < K_MAX - 1; i++) begin
                r_cd[i]  <= r_cd[i+1];
                r_cid[i] <= r_cid[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.clear_held) begin
            r_held <= '0;
        end else if (w_insert && (r_held < CNT_W'(K_MAX))) begin
            r_held <= r_held + CNT_W'(1);
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ofound <= i_cmd.out_found;
            r_olast  <= i_cmd.out_last;
            r_orank  <= i_cmd.out_found ? i_cmd.out_rank : '0;
            r_oid    <= i_cmd.out_found ? r_cid[0] : '0;
            r_odist  <= i_cmd.out_found ? r_cd[0] : '0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ofound;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = OUT_TD_W'({r_odist, r_oid, r_orank});

endmodule

/* sv/knps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knps_ctrl
// Sequencer: opens the input, sizes the report and steps out the beats.
// ----------------------------------------------------------------------------
module knps_ctrl
    import knps_pkg::*;
#(
    parameter int K_MAX  = K_MAX_DEF,
    localparam int CNT_W = $clog2(K_MAX + 1),
    localparam int CMP_W = (CNT_W > NC_W) ? CNT_W : NC_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_sts          i_sts,
    input  logic [CNT_W-1:0] i_held,
    output t_dp_cmd          o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rank,  n_rank;
    logic [CMP_W-1:0] w_sat;
    logic [CMP_W-1:0] w_min;
    logic             w_last;

    // report size: count saturated to the list depth, then to what is held
    always_comb begin
        w_sat  = (CMP_W'(i_sts.nc) > CMP_W'(K_MAX)) ? CMP_W'(K_MAX) : CMP_W'(i_sts.nc);
        w_min  = (w_sat > CMP_W'(i_held)) ? CMP_W'(i_held) : w_sat;
        w_last = (r_rank + CNT_W'(1)) == r_count;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (i_sts.end_insert) n_state = ST_COUNT;
            end
            ST_COUNT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free && ((r_count == '0) || w_last)) n_state = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_rank  = r_rank;
        if (r_state == ST_COUNT) begin
            n_count = CNT_W'(w_min);
            n_rank  = '0;
        end else if ((r_state == ST_EMIT) && i_sts.out_free && !w_last) begin
            n_rank  = r_rank + CNT_W'(1);
        end
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_RUN: begin
                o_cmd.in_open = 1'b1;
            end
            ST_COUNT: begin
                o_cmd.in_open = 1'b0;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_count == '0) begin
                        o_cmd.out_last   = 1'b1;
                        o_cmd.clear_held = 1'b1;
                    end else begin
                        o_cmd.out_found  = 1'b1;
                        o_cmd.out_rank   = RANK_W'(r_rank);
                        o_cmd.out_last   = w_last;
                        o_cmd.shift_out  = 1'b1;
                        o_cmd.clear_held = w_last;
                    end
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_count <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

endmodule

/* test/knps_report_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knps_report_checker
// Watches the config, candidate and report channels of the k-nearest point
// selector. Keeps its own sorted neighbor list, builds the report beats each
// batch should produce and compares every report beat with the oldest one.
// ----------------------------------------------------------------------------
module knps_report_checker
    import knps_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    localparam int DIST_W    = 2 * COORD_BITS + 2,
    localparam int IN_TD_W   = ((ID_BITS + 3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TD_W  = ((RANK_W + ID_BITS + DIST_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COORD_BITS-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_TD_W-1:0]    s_axis_tdata,  // cand_id, cand_x, cand_y, cand_z
    input  logic                  s_axis_tlast,  // batch_end
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_TD_W-1:0]   m_axis_tdata,  // rank, point_id, sq_distance
    input  logic [0:0]            m_axis_tuser,  // found
    input  logic                  m_axis_tlast,  // run_last
    output int                    o_fail_count,
    output int                    o_outstanding,
    output int                    o_beats_checked
);

    typedef struct {
        logic              found;
        logic [RANK_W-1:0] rank;
        logic [ID_BITS-1:0] point_id;
        logic [DIST_W-1:0] sq_distance;
        logic              run_last;
    } t_report;

    logic [COORD_BITS-1:0] query_x;
    logic [COORD_BITS-1:0] query_y;
    logic [COORD_BITS-1:0] query_z;
    logic [NC_W-1:0]       keep_count;

    logic [DIST_W-1:0]  nearest_dist [K_MAX];
    logic [ID_BITS-1:0] nearest_id   [K_MAX];
    int                 nearest_held;

    t_report pending_reports[$];
    int      fail_count = 0;
    int      beats_checked = 0;

    function automatic longint axis_sq(input logic [COORD_BITS-1:0] a,
                                       input logic [COORD_BITS-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return d * d;
    endfunction

    // new point goes ahead of equal distances, farthest falls off a full list
    task automatic insert_nearest(input logic [ID_BITS-1:0] id,
                                  input logic [DIST_W-1:0] new_dist);
        int pos;
        int top;
        pos = nearest_held;
        for (int i = 0; i < nearest_held; i++) begin
            if (new_dist <= nearest_dist[i]) begin
                pos = i;
                break;
            end
        end
        if (pos < K_MAX) begin
            top = (nearest_held < K_MAX) ? nearest_held : K_MAX - 1;
            for (int i = top; i > pos; i--) begin
                nearest_dist[i] = nearest_dist[i-1];
                nearest_id[i]   = nearest_id[i-1];
            end
            nearest_dist[pos] = new_dist;
            nearest_id[pos]   = id;
            if (nearest_held < K_MAX)
                nearest_held++;
        end
    endtask

    task automatic close_batch();
        int      count;
        t_report rep;
        count = (int'(keep_count) > K_MAX) ? K_MAX : int'(keep_count);
        if (count > nearest_held)
            count = nearest_held;
        if (count == 0) begin
            rep.found       = 1'b0;
            rep.rank        = '0;
            rep.point_id    = '0;
            rep.sq_distance = '0;
            rep.run_last    = 1'b1;
            pending_reports.insert(pending_reports.size(), rep);
        end else begin
            for (int k = 0; k < count; k++) begin
                rep.found       = 1'b1;
                rep.rank        = RANK_W'(k);
                rep.point_id    = nearest_id[k];
                rep.sq_distance = nearest_dist[k];
                rep.run_last    = (k + 1 == count);
                pending_reports.insert(pending_reports.size(), rep);
            end
        end
        nearest_held = 0;
    endtask

    task automatic take_candidate();
        logic [ID_BITS-1:0]    id;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
        logic [DIST_W-1:0]     cand_dist;
        id   = s_axis_tdata[ID_BITS-1:0];
        cx   = s_axis_tdata[ID_BITS +: COORD_BITS];
        cy   = s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
        cz   = s_axis_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS];
        cand_dist = DIST_W'(axis_sq(cx, query_x) + axis_sq(cy, query_y)
                            + axis_sq(cz, query_z));
        if (cand_dist != '0)
            insert_nearest(id, cand_dist);
        if (s_axis_tlast)
            close_batch();
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("report beat %0d: %s expected %0h, got %0h",
                         beats_checked, field, want, got);
        end
    endtask

    task automatic check_report();
        t_report want;
        beats_checked++;
        if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("report beat %0d arrived with nothing expected, tdata %0h",
                         beats_checked, m_axis_tdata);
        end else begin
            want = pending_reports.pop_front();
            compare_field("found", 64'(want.found), 64'(m_axis_tuser[0]));
            compare_field("rank", 64'(want.rank), 64'(m_axis_tdata[RANK_W-1:0]));
            compare_field("point_id", 64'(want.point_id),
                          64'(m_axis_tdata[RANK_W +: ID_BITS]));
            compare_field("sq_distance", 64'(want.sq_distance),
                          64'(m_axis_tdata[RANK_W + ID_BITS +: DIST_W]));
            compare_field("run_last", 64'(want.run_last), 64'(m_axis_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            query_x      = '0;
            query_y      = '0;
            query_z      = '0;
            keep_count   = NC_RESET;
            nearest_held = 0;
            pending_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_QUERY_X:        query_x    = i_cfg_wdata;
                    CFG_QUERY_Y:        query_y    = i_cfg_wdata;
                    CFG_QUERY_Z:        query_z    = i_cfg_wdata;
                    CFG_NEIGHBOR_COUNT: keep_count = i_cfg_wdata[NC_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            if (s_axis_tvalid && s_axis_tready)
                take_candidate();
        end
        o_fail_count    <= fail_count;
        o_outstanding   <= pending_reports.size();
        o_beats_checked <= beats_checked;
    end

endmodule

/* test/k_nearest_point_select_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_point_select_core_tb
// Drives candidate batches and register settings into the k-nearest point
// selector: a directed opening on extreme coordinates, ties, zero distance,
// overfull lists and odd neighbor counts, then random batches under several
// query settings and idle mixes. A checker beside the block scores reports.
// ----------------------------------------------------------------------------
module k_nearest_point_select_core_tb;
    import knps_pkg::*;

    localparam int K_MAX      = K_MAX_DEF;
    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int ID_BITS    = ID_BITS_DEF;
    localparam int DIST_W     = 2 * COORD_BITS + 2;
    localparam int IN_TD_W    = ((ID_BITS + 3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TD_W   = ((RANK_W + ID_BITS + DIST_W + 7) / 8) * 8;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int SETTLE_CYCLES     = 20;
    localparam int RX_HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_SETTING = 48;

    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] COORD_NEG_ONE = {COORD_BITS{1'b1}};

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [COORD_BITS-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TD_W-1:0]    s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0]   m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    int checker_fails;
    int checker_outstanding;
    int checker_beats;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit rx_hold_req   = 1'b0;
    bit rx_hold_ack   = 1'b0;
    int rx_hold_left  = 0;
    int cycle_count   = 0;
    int cand_total    = 0;
    int batch_total   = 0;

    logic [COORD_BITS-1:0] cur_qx = '0;
    logic [COORD_BITS-1:0] cur_qy = '0;
    logic [COORD_BITS-1:0] cur_qz = '0;
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic [COORD_BITS-1:0] prev_z;
    bit                    have_prev = 1'b0;

    k_nearest_point_select_core #(
        .K_MAX      (K_MAX),
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    knps_report_checker #(
        .K_MAX      (K_MAX),
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) report_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (checker_fails),
        .o_outstanding   (checker_outstanding),
        .o_beats_checked (checker_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // report side backpressure, with a long hold on request
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack   <= rx_hold_req;
            rx_hold_left  <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d report beats still expected",
                     cycle_count, checker_outstanding);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_cand(input logic [ID_BITS-1:0] id, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z,
                             input logic last);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TD_W'({z, y, x, id});
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        cand_total++;
        if (last)
            batch_total++;
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (checker_outstanding != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_ADDR_W-1:0] addr,
                            input logic [COORD_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [COORD_BITS-1:0] qx,
                                 input logic [COORD_BITS-1:0] qy,
                                 input logic [COORD_BITS-1:0] qz,
                                 input logic [NC_W-1:0] nc);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_beat(CFG_QUERY_X, qx);
        cfg_beat(CFG_QUERY_Y, qy);
        cfg_beat(CFG_QUERY_Z, qz);
        cfg_beat(CFG_NEIGHBOR_COUNT, COORD_BITS'(nc));
        i_cfg_we  <= 1'b0;
        cur_qx    = qx;
        cur_qy    = qy;
        cur_qz    = qz;
        have_prev = 1'b0;
    endtask

    function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] q);
        logic [COORD_BITS-1:0] off;
        off = COORD_BITS'($urandom() >> $urandom_range(31, 9));
        return ($urandom_range(1, 0) != 0) ? q + off : q - off;
    endfunction

    // mostly points around the query, some repeats for ties, some far or exact
    task automatic send_random_batch();
        int                    len;
        int                    pick;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(15, 0);
            if (pick < 4) begin
                x = COORD_BITS'($urandom());
                y = COORD_BITS'($urandom());
                z = COORD_BITS'($urandom());
            end else if (pick == 4) begin
                x = cur_qx;
                y = cur_qy;
                z = cur_qz;
            end else if (pick < 7 && have_prev) begin
                x = prev_x;
                y = prev_y;
                z = prev_z;
            end else begin
                x = near_coord(cur_qx);
                y = near_coord(cur_qy);
                z = near_coord(cur_qz);
            end
            prev_x    = x;
            prev_y    = y;
            prev_z    = z;
            have_prev = 1'b1;
            send_cand(ID_BITS'($urandom_range(65535, 0)), x, y, z, i == len - 1);
        end
    endtask

    initial begin
        int start_items;
        int setting;
        int batches_here;
        logic [NC_W-1:0] nc;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero distance end gives an empty report
        send_cand('0, '0, '0, '0, 1'b1);
        // equal distances, the later one ranks first
        send_cand('1, COORD_ONE, '0, '0, 1'b0);
        send_cand(ID_BITS'(1), COORD_NEG_ONE, '0, '0, 1'b1);

        // widest spread, count above list size, fewer held than asked
        write_setting(COORD_MAX, COORD_MAX, COORD_MAX, NC_W'(20));
        send_cand(ID_BITS'(2), COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_cand(ID_BITS'(3), COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_cand(ID_BITS'(4), '0, '0, '0, 1'b1);

        // overfull list: the far point falls off, then the farthest near point
        write_setting(COORD_MIN, COORD_MIN, COORD_MIN, NC_W'(K_MAX));
        send_cand(ID_BITS'(10), COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        for (int i = 1; i < 18; i++)
            send_cand(ID_BITS'(10 + i), COORD_MIN + COORD_BITS'((i * 7) % 17 + 1),
                      COORD_MIN, COORD_MIN, i == 17);

        // zero count reports nothing even with a point held
        write_setting('0, '0, '0, '0);
        send_cand(ID_BITS'(5), COORD_BITS'(5), COORD_BITS'(5), COORD_BITS'(5), 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            for (int s = 0; s < 2; s++) begin
                setting = mode * 2 + s;
                case (setting)
                    0: nc = NC_W'(K_MAX);
                    1: nc = NC_W'(1);
                    2: nc = NC_W'(31);
                    3: nc = NC_W'(5);
                    4: nc = NC_W'(20);
                    default: nc = NC_W'($urandom_range(K_MAX, 1));
                endcase
                if (setting == 1)
                    write_setting(COORD_MAX, COORD_MAX, COORD_MAX, nc);
                else if (setting == 3)
                    write_setting(COORD_MIN, COORD_MIN, COORD_MIN, nc);
                else
                    write_setting(COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                                  COORD_BITS'($urandom()), nc);
                if (s == 0) begin
                    tx_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 47 : 0;
                    rx_idle_pct <= (mode == 0) ? 47 : (mode == 1) ? 22 : 0;
                end
                if (setting == 0)
                    rx_hold_req <= ~rx_hold_req;
                start_items  = cand_total;
                batches_here = 0;
                while (cand_total - start_items < ITEMS_PER_SETTING) begin
                    send_random_batch();
                    batches_here++;
                    if (setting == 2 && batches_here == 2)
                        drain_reports();
                end
            end
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d candidates in %0d batches over ten register settings",
                 cand_total, batch_total);
        $display("checked %0d report beats across three idle mixes and a long output hold",
                 checker_beats);
        if (checker_fails == 0 && checker_outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
